/* design/fts_pkg.sv */
// Shared types and constants for the forwarding table with port sets.
// No dependencies; every other design file refers to this package.
`default_nettype none
package fts_pkg;
	localparam int TABLE_ENTRIES   = 64;
	localparam int PORTS_PER_ENTRY = 8;
	localparam int IDX_W   = $clog2(TABLE_ENTRIES);
	localparam int CNT_W   = $clog2(PORTS_PER_ENTRY + 1);
	localparam int VCNT_W  = $clog2(TABLE_ENTRIES + 1);
	localparam int PADDR_W = $clog2(TABLE_ENTRIES * PORTS_PER_ENTRY);

	localparam logic [1:0] ACT_ADD    = 2'd0;
	localparam logic [1:0] ACT_REMOVE = 2'd1;
	localparam logic [1:0] ACT_LOOKUP = 2'd2;
	localparam logic [1:0] ACT_FLUSH  = 2'd3;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_INVALID   = 2'd2;
	localparam logic [1:0] ST_FULL      = 2'd3;

	typedef enum logic [2:0] {
		OP_ADD, OP_REMOVE, OP_LOOKUP, OP_FLUSH, OP_INVALID
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [31:0] dst;
		logic [7:0]  qos;
		logic [15:0] port;
		logic        has;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] port;
		logic        pvalid;
		logic        last;
		logic        empty;
	} res_t;

	typedef struct packed {
		logic [31:0]      dst;
		logic [7:0]       qos;
		logic [CNT_W-1:0] cnt;
	} key_word_t;

	typedef enum logic [3:0] {
		BS_IDLE, BS_SCAN, BS_SCAN_END, BS_DECIDE, BS_PSCAN, BS_PCMP, BS_PDONE,
		BS_SHRD, BS_SHWR, BS_LRD, BS_LEMIT, BS_EMIT
	} bstate_t;
endpackage
`default_nettype wire

/* design/fts_front.sv */
// Front end: accepts requests, classifies them and queues them for the back end.
// Depends on fts_pkg.
`default_nettype none
module fts_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire logic [1:0]    action,
	input  wire logic [31:0]   destination,
	input  wire logic [7:0]    qos_id,
	input  wire logic [15:0]   port_id,
	input  wire logic          has_port,
	output logic               q_valid,
	output fts_pkg::req_t      q_req,
	input  wire logic          q_pop
);
	fts_pkg::req_t fifo_q [2];
	fts_pkg::req_t cls;
	logic          wr_q, rd_q;
	logic [1:0]    cnt_q;
	logic          push;

	// classify the request
	always_comb begin
		cls.dst  = destination;
		cls.qos  = qos_id;
		cls.port = port_id;
		cls.has  = has_port;
		if (action == fts_pkg::ACT_FLUSH) begin
			cls.op = fts_pkg::OP_FLUSH;
		end else if (destination == 32'd0) begin
			cls.op = fts_pkg::OP_INVALID;
		end else begin
			unique case (action)
				fts_pkg::ACT_ADD:    cls.op = fts_pkg::OP_ADD;
				fts_pkg::ACT_REMOVE: cls.op = fts_pkg::OP_REMOVE;
				default:             cls.op = fts_pkg::OP_LOOKUP;
			endcase
		end
	end

	assign in_stall = (cnt_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_req    = fifo_q[rd_q];

	// two-entry request queue
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (q_pop) rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end
endmodule
`default_nettype wire

/* design/fts_back.sv */
// Back end: table search, port set updates and lookup streaming.
// Depends on fts_pkg; holds the key/count memory and the port memory.
`default_nettype none
module fts_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          q_valid,
	input  wire fts_pkg::req_t q_req,
	output logic               q_pop,
	output logic               res_valid,
	output fts_pkg::res_t      res,
	input  wire logic          res_rdy
);
	localparam int PPE = fts_pkg::PORTS_PER_ENTRY;
	localparam int NE  = fts_pkg::TABLE_ENTRIES;

	fts_pkg::key_word_t key_mem [NE];
	logic [15:0]        port_mem [NE*PPE];

	fts_pkg::bstate_t   st_q, st_nxt;
	fts_pkg::req_t      req_q;
	fts_pkg::key_word_t key_rd_q, key_wd;
	logic [15:0]        port_rd_q, port_wd;
	logic               key_we, port_we;
	logic [fts_pkg::IDX_W-1:0]   key_wa;
	logic [fts_pkg::PADDR_W-1:0] port_wa, port_ra, base;

	logic [NE-1:0]               valid_q;
	logic [fts_pkg::VCNT_W-1:0]  vcnt_q;
	logic [fts_pkg::IDX_W-1:0]   idx_q, chk_idx_q, fidx_q, free_q, e_q;
	logic                        chk_q, found_q, free_ok_q, hit_q, more_q;
	logic [fts_pkg::CNT_W-1:0]   fcnt_q, n_q, j_q;
	logic                        key_hit, port_match, sh_more;
	logic [1:0]                  rstat_q;
	logic [15:0]                 rport_q;
	logic                        rpv_q, rlast_q;

	assign key_hit = chk_q && valid_q[chk_idx_q] && key_rd_q.dst == req_q.dst
		&& key_rd_q.qos == req_q.qos;
	assign port_match = (port_rd_q == req_q.port);
	assign sh_more = ({1'b0, j_q} + 1'b1) < {1'b0, n_q};
	assign base = fts_pkg::PADDR_W'(e_q) * fts_pkg::PADDR_W'(PPE);

	// next state
	always_comb begin
		st_nxt = st_q;
		unique case (st_q)
			fts_pkg::BS_IDLE: begin
				if (q_valid) begin
					if (q_req.op == fts_pkg::OP_FLUSH || q_req.op == fts_pkg::OP_INVALID)
						st_nxt = fts_pkg::BS_EMIT;
					else
						st_nxt = fts_pkg::BS_SCAN;
				end
			end
			fts_pkg::BS_SCAN:
				if (idx_q == fts_pkg::IDX_W'(NE - 1)) st_nxt = fts_pkg::BS_SCAN_END;
			fts_pkg::BS_SCAN_END: st_nxt = fts_pkg::BS_DECIDE;
			fts_pkg::BS_DECIDE: begin
				st_nxt = fts_pkg::BS_EMIT;
				case (req_q.op)
					fts_pkg::OP_ADD:
						if ((found_q || free_ok_q) && req_q.has) st_nxt = fts_pkg::BS_PSCAN;
					fts_pkg::OP_REMOVE:
						if (found_q && req_q.has) st_nxt = fts_pkg::BS_PSCAN;
					default:
						if (found_q && fcnt_q != '0) st_nxt = fts_pkg::BS_LRD;
				endcase
			end
			fts_pkg::BS_PSCAN:
				st_nxt = (j_q == n_q) ? fts_pkg::BS_PDONE : fts_pkg::BS_PCMP;
			fts_pkg::BS_PCMP:
				st_nxt = port_match ? fts_pkg::BS_PDONE : fts_pkg::BS_PSCAN;
			fts_pkg::BS_PDONE:
				st_nxt = (req_q.op == fts_pkg::OP_REMOVE && hit_q) ? fts_pkg::BS_SHRD
					: fts_pkg::BS_EMIT;
			fts_pkg::BS_SHRD:
				st_nxt = sh_more ? fts_pkg::BS_SHWR : fts_pkg::BS_EMIT;
			fts_pkg::BS_SHWR: st_nxt = fts_pkg::BS_SHRD;
			fts_pkg::BS_LRD:  st_nxt = fts_pkg::BS_LEMIT;
			fts_pkg::BS_LEMIT: st_nxt = fts_pkg::BS_EMIT;
			fts_pkg::BS_EMIT:
				if (res_rdy) st_nxt = more_q ? fts_pkg::BS_LRD : fts_pkg::BS_IDLE;
			default: st_nxt = fts_pkg::BS_IDLE;
		endcase
	end

	// memory controls and handshake outputs
	always_comb begin
		key_we  = 1'b0;
		key_wa  = e_q;
		key_wd  = '{dst: req_q.dst, qos: req_q.qos, cnt: n_q};
		port_we = 1'b0;
		port_wa = base + fts_pkg::PADDR_W'(j_q);
		port_wd = port_rd_q;
		port_ra = base + fts_pkg::PADDR_W'(j_q);
		q_pop   = (st_q == fts_pkg::BS_IDLE) && q_valid;
		res_valid = (st_q == fts_pkg::BS_EMIT);
		res = '{status: rstat_q, port: rport_q, pvalid: rpv_q, last: rlast_q,
			empty: (vcnt_q == '0)};
		case (st_q)
			fts_pkg::BS_DECIDE: begin
				if (req_q.op == fts_pkg::OP_ADD && !found_q && free_ok_q) begin
					key_we = 1'b1;
					key_wa = free_q;
					key_wd.cnt = '0;
				end
			end
			fts_pkg::BS_PDONE: begin
				if (req_q.op == fts_pkg::OP_ADD && !hit_q
						&& n_q != fts_pkg::CNT_W'(PPE)) begin
					port_we = 1'b1;
					port_wa = base + fts_pkg::PADDR_W'(n_q);
					port_wd = req_q.port;
					key_we  = 1'b1;
					key_wd.cnt = n_q + 1'b1;
				end
			end
			fts_pkg::BS_SHRD: begin
				port_ra = base + fts_pkg::PADDR_W'(j_q) + 1'b1;
				if (!sh_more) begin
					key_we = 1'b1;
					key_wd.cnt = n_q - 1'b1;
				end
			end
			fts_pkg::BS_SHWR: port_we = 1'b1;
			default: ;
		endcase
	end

	// memories
	always_ff @(posedge clk) begin
		if (key_we) key_mem[key_wa] <= key_wd;
		key_rd_q <= key_mem[idx_q];
		if (port_we) port_mem[port_wa] <= port_wd;
		port_rd_q <= port_mem[port_ra];
	end

	// request and datapath registers
	always_ff @(posedge clk) begin
		chk_idx_q <= idx_q;
		if (q_pop) req_q <= q_req;
		if (key_hit) begin
			fidx_q <= chk_idx_q;
			fcnt_q <= key_rd_q.cnt;
		end
		if (chk_q && !valid_q[chk_idx_q] && !free_ok_q) free_q <= chk_idx_q;
		if (st_q == fts_pkg::BS_DECIDE) begin
			e_q <= found_q ? fidx_q : free_q;
			n_q <= found_q ? fcnt_q : '0;
		end
		if (st_q == fts_pkg::BS_SHRD && !sh_more) n_q <= n_q - 1'b1;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= fts_pkg::BS_IDLE;
			valid_q   <= '0;
			vcnt_q    <= '0;
			idx_q     <= '0;
			chk_q     <= 1'b0;
			found_q   <= 1'b0;
			free_ok_q <= 1'b0;
			hit_q     <= 1'b0;
			more_q    <= 1'b0;
			j_q       <= '0;
			rstat_q   <= fts_pkg::ST_OK;
			rport_q   <= '0;
			rpv_q     <= 1'b0;
			rlast_q   <= 1'b1;
		end else begin
			st_q  <= st_nxt;
			chk_q <= (st_q == fts_pkg::BS_SCAN);
			if (key_hit) found_q <= 1'b1;
			if (chk_q && !valid_q[chk_idx_q]) free_ok_q <= 1'b1;
			unique case (st_q)
				fts_pkg::BS_IDLE: begin
					idx_q <= '0; found_q <= 1'b0; free_ok_q <= 1'b0; hit_q <= 1'b0;
					j_q <= '0; more_q <= 1'b0;
					rport_q <= '0; rpv_q <= 1'b0; rlast_q <= 1'b1;
					rstat_q <= (q_valid && q_req.op == fts_pkg::OP_INVALID)
						? fts_pkg::ST_INVALID : fts_pkg::ST_OK;
					if (q_valid && q_req.op == fts_pkg::OP_FLUSH) begin
						valid_q <= '0;
						vcnt_q  <= '0;
					end
				end
				fts_pkg::BS_SCAN: idx_q <= idx_q + 1'b1;
				fts_pkg::BS_SCAN_END: ;
				fts_pkg::BS_DECIDE: begin
					// lookups stream from the newest port down
					j_q <= (req_q.op == fts_pkg::OP_LOOKUP && found_q)
						? fcnt_q - 1'b1 : '0;
					case (req_q.op)
						fts_pkg::OP_ADD: begin
							if (!found_q && !free_ok_q) begin
								rstat_q <= fts_pkg::ST_FULL;
							end else if (!found_q) begin
								valid_q[free_q] <= 1'b1;
								vcnt_q <= vcnt_q + 1'b1;
							end
						end
						fts_pkg::OP_REMOVE: begin
							if (!found_q) begin
								rstat_q <= fts_pkg::ST_NOT_FOUND;
							end else if (!req_q.has && fcnt_q == '0) begin
								valid_q[fidx_q] <= 1'b0;
								vcnt_q <= vcnt_q - 1'b1;
							end
						end
						default:
							if (!found_q) rstat_q <= fts_pkg::ST_NOT_FOUND;
					endcase
				end
				fts_pkg::BS_PSCAN: ;
				fts_pkg::BS_PCMP: begin
					if (port_match) hit_q <= 1'b1;
					else j_q <= j_q + 1'b1;
				end
				fts_pkg::BS_PDONE: begin
					if (req_q.op == fts_pkg::OP_ADD) begin
						if (!hit_q && n_q == fts_pkg::CNT_W'(PPE)) begin
							valid_q[e_q] <= 1'b0;
							vcnt_q  <= vcnt_q - 1'b1;
							rstat_q <= fts_pkg::ST_FULL;
						end
					end else if (!hit_q && n_q == '0) begin
						valid_q[e_q] <= 1'b0;
						vcnt_q <= vcnt_q - 1'b1;
					end
				end
				fts_pkg::BS_SHRD: begin
					if (!sh_more && n_q == fts_pkg::CNT_W'(1)) begin
						valid_q[e_q] <= 1'b0;
						vcnt_q <= vcnt_q - 1'b1;
					end
				end
				fts_pkg::BS_SHWR: j_q <= j_q + 1'b1;
				fts_pkg::BS_LRD: ;
				fts_pkg::BS_LEMIT: begin
					rport_q <= port_rd_q;
					rpv_q   <= 1'b1;
					rlast_q <= (j_q == '0);
					more_q  <= (j_q != '0);
				end
				fts_pkg::BS_EMIT:
					if (res_rdy && more_q) j_q <= j_q - 1'b1;
				default: ;
			endcase
		end
	end

	// checks
	a_vcnt: assert property (@(posedge clk) disable iff (!arst_n)
		vcnt_q == fts_pkg::VCNT_W'($countones(valid_q)))
		else $error("valid count out of step with valid bits");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> st_q != fts_pkg::BS_IDLE)
		else $error("request popped without leaving idle");
	a_lemit: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == fts_pkg::BS_LEMIT |-> n_q != '0 && j_q < n_q)
		else $error("lookup read outside port set");
	a_more: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && more_q |-> rpv_q && !rlast_q)
		else $error("continued lookup result without port");
endmodule
`default_nettype wire

/* design/forwarding_table_port_sets.sv */
// Forwarding table with port sets: each accepted request runs a key scan through
// the key memory, then searches or shifts port slots as needed; flush and
// invalid-key requests go straight to the result.
// The back end handles one request at a time; lookups stream their results, one
// port per result, and out_stall can hold them; two requests queue up front.
// Reset clears the table (all valid bits) and the queues; memories need no clearing.
`default_nettype none
module forwarding_table_port_sets (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  action,
	input  wire logic [31:0] destination,
	input  wire logic [7:0]  qos_id,
	input  wire logic [15:0] port_id,
	input  wire logic        has_port,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       status,
	output logic [15:0]      port_id_res,
	output logic             port_valid,
	output logic             last,
	output logic             table_empty
);
	logic          q_valid, q_pop, res_valid, res_rdy;
	fts_pkg::req_t q_req;
	fts_pkg::res_t res, out_q;
	logic          out_vld_q;

	fts_front u_front (
		.clk, .arst_n, .in_valid, .in_stall, .action, .destination, .qos_id,
		.port_id, .has_port, .q_valid, .q_req, .q_pop
	);

	fts_back u_back (
		.clk, .arst_n, .q_valid, .q_req, .q_pop, .res_valid, .res, .res_rdy
	);

	// output register
	assign res_rdy = !out_vld_q || !out_stall;

	always_ff @(posedge clk) begin
		if (res_valid && res_rdy) out_q <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (res_rdy) begin
			out_vld_q <= res_valid;
		end
	end

	assign out_valid   = out_vld_q;
	assign status      = out_q.status;
	assign port_id_res = out_q.port;
	assign port_valid  = out_q.pvalid;
	assign last        = out_q.last;
	assign table_empty = out_q.empty;
endmodule
`default_nettype wire
